### design/stid_pkg.sv
`default_nettype none
package stid_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH  = 32;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int POS_BITS     = 5;
    localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);

    // Operation codes carried on the mode field.
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_READ   = 2'd2
    } t_mode;

    // One table entry.
    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    // Per-cell control produced by the table controller.
    typedef struct packed {
        logic insert;   // an insert is being applied this cycle
        logic delete;   // a delete is being applied this cycle
        logic occupied; // this cell holds a live entry
        logic at_end;   // this cell is the first free place
        logic past_pos; // this cell is at or above the delete position
    } t_cell_ctl;

endpackage
`default_nettype wire

### design/stid_cell.sv
`default_nettype none
module stid_cell (
    input  wire                  i_clk,
    input  wire stid_pkg::t_cell_ctl i_ctl,
    input  wire stid_pkg::t_entry    i_new,
    input  wire stid_pkg::t_entry    i_left,
    input  wire                  i_left_gt,
    input  wire stid_pkg::t_entry    i_right,
    output stid_pkg::t_entry     o_entry,
    output logic                 o_gt
);
    import stid_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // The held key orders after the new key, so this cell moves up on insert.
    assign o_gt    = i_ctl.occupied && (r_entry.key > i_new.key);
    assign o_entry = r_entry;

    // Insert: take the left neighbor when it moves up, else the new entry if
    // this is the insertion point. Delete: past_pos takes the right neighbor.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.insert) begin
            if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt || i_ctl.at_end) begin
                n_entry = i_new;
            end
        end else if (i_ctl.delete && i_ctl.past_pos) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

### design/sorted_table_insert_delete.sv
// Sorted insertion table with insert, delete-by-position and read-by-position.
// Input channel: i_valid / o_ready carry i_mode, i_entry_key, i_entry_payload
// and i_position; a transfer happens when both are high. Output channel:
// o_valid / i_ready carry o_ok, o_read_key, o_read_payload and o_entry_count.
// The result of each operation is registered and shows on the output in
// the cycle after the input transfer. Every cell of the row compares
// its key with the new key in parallel and shifts to its neighbor in the
// same cycle, so one operation can be accepted each cycle, limited only by
// the single result register.
// When the receiver stalls, the result register holds and o_ready drops until
// the pending result is taken; a new input is accepted in the same cycle the
// old result is taken.
// Reset (i_rst_n low, synchronous) empties the table and clears the output
// valid; entry contents are not cleared and are never visible, since only
// places below the entry count are read.
`default_nettype none
module sorted_table_insert_delete (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [1:0]                         i_mode,
    input  wire  [stid_pkg::KEY_BITS-1:0]      i_entry_key,
    input  wire  [stid_pkg::PAYLOAD_BITS-1:0]  i_entry_payload,
    input  wire  [stid_pkg::POS_BITS-1:0]      i_position,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic                               o_ok,
    output logic [stid_pkg::KEY_BITS-1:0]      o_read_key,
    output logic [stid_pkg::PAYLOAD_BITS-1:0]  o_read_payload,
    output logic [stid_pkg::CNT_BITS-1:0]      o_entry_count
);
    import stid_pkg::*;

    logic                    r_valid;
    logic [CNT_BITS-1:0]     r_count;
    logic                    r_ok;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;

    logic                    n_ok;
    logic [KEY_BITS-1:0]     n_key;
    logic [PAYLOAD_BITS-1:0] n_payload;
    logic [CNT_BITS-1:0]     n_count;

    logic                    w_accept;
    logic                    w_full;
    logic                    w_pos_ok;
    logic                    w_do_insert;
    logic                    w_do_delete;
    logic [CNT_BITS-1:0]     w_pos;
    t_entry                  w_new;
    t_entry                  w_entry [TABLE_DEPTH];
    logic                    w_gt    [TABLE_DEPTH];
    t_cell_ctl               w_ctl   [TABLE_DEPTH];

    // Handshake: take a new operation whenever the result register is free
    // or being emptied this cycle.
    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    assign w_new.key     = i_entry_key;
    assign w_new.payload = i_entry_payload;
    assign w_pos         = CNT_BITS'(i_position);
    assign w_full        = (r_count == CNT_BITS'(TABLE_DEPTH));
    assign w_pos_ok      = (w_pos < r_count);
    assign w_do_insert   = w_accept && (t_mode'(i_mode) == MODE_INSERT) && !w_full;
    assign w_do_delete   = w_accept && (t_mode'(i_mode) == MODE_DELETE) && w_pos_ok;

    // Row of cells, each linked to both neighbors.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign w_ctl[g].insert   = w_do_insert;
        assign w_ctl[g].delete   = w_do_delete;
        assign w_ctl[g].occupied = (CNT_BITS'(g) < r_count);
        assign w_ctl[g].at_end   = (CNT_BITS'(g) == r_count);
        assign w_ctl[g].past_pos = (CNT_BITS'(g) >= w_pos);

        stid_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl[g]),
            .i_new     (w_new),
            .i_left    ((g == 0) ? w_new : w_entry[(g == 0) ? 0 : g - 1]),
            .i_left_gt ((g == 0) ? 1'b0 : w_gt[(g == 0) ? 0 : g - 1]),
            .i_right   (w_entry[(g == TABLE_DEPTH - 1) ? g : g + 1]),
            .o_entry   (w_entry[g]),
            .o_gt      (w_gt[g])
        );
    end

    // Result of the accepted operation.
    always_comb begin
        n_ok      = 1'b0;
        n_key     = '0;
        n_payload = '0;
        n_count   = r_count;
        case (t_mode'(i_mode))
            MODE_INSERT: begin
                if (!w_full) begin
                    n_ok    = 1'b1;
                    n_count = r_count + CNT_BITS'(1);
                end
            end
            MODE_DELETE: begin
                if (w_pos_ok) begin
                    n_ok    = 1'b1;
                    n_count = r_count - CNT_BITS'(1);
                end
            end
            MODE_READ: begin
                if (w_pos_ok) begin
                    n_ok      = 1'b1;
                    n_key     = w_entry[i_position[IDX_BITS-1:0]].key;
                    n_payload = w_entry[i_position[IDX_BITS-1:0]].payload;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Entry count, result register and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_ok      <= n_ok;
            r_key     <= n_key;
            r_payload <= n_payload;
        end
    end

    assign o_valid        = r_valid;
    assign o_ok           = r_ok;
    assign o_read_key     = r_key;
    assign o_read_payload = r_payload;
    assign o_entry_count  = r_count;

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps

import stid_pkg::*;

// One result as the block reports it.
typedef struct packed {
    logic                    ok;
    logic [KEY_BITS-1:0]     read_key;
    logic [PAYLOAD_BITS-1:0] read_payload;
    logic [CNT_BITS-1:0]     entry_count;
} table_result_t;

// Shadow copy of the sorted table together with the results still owed by the block.
class sorted_table_shadow;
    logic [KEY_BITS-1:0]     keys [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0] payloads [TABLE_DEPTH];
    int unsigned             fill;
    table_result_t           expected_results [$];
    int unsigned             errors;

    function new();
        fill   = 0;
        errors = 0;
    endfunction

    function int unsigned level();
        return fill;
    endfunction

    function int unsigned outstanding();
        return expected_results.size();
    endfunction

    // Apply one accepted operation to the shadow table and queue its result.
    function void apply_op(logic [1:0] mode, logic [KEY_BITS-1:0] key,
                           logic [PAYLOAD_BITS-1:0] payload, logic [POS_BITS-1:0] pos);
        table_result_t res;
        int unsigned   slot;
        res = '0;
        case (mode)
            MODE_INSERT: begin
                if (fill < TABLE_DEPTH) begin
                    // Equal keys stay in arrival order, so skip past them.
                    slot = 0;
                    while (slot < fill && keys[slot] <= key)
                        slot++;
                    for (int j = fill; j > slot; j--) begin
                        keys[j]     = keys[j-1];
                        payloads[j] = payloads[j-1];
                    end
                    keys[slot]     = key;
                    payloads[slot] = payload;
                    fill++;
                    res.ok = 1'b1;
                end
            end
            MODE_DELETE: begin
                if (pos < fill) begin
                    for (int j = pos; j + 1 < fill; j++) begin
                        keys[j]     = keys[j+1];
                        payloads[j] = payloads[j+1];
                    end
                    fill--;
                    res.ok = 1'b1;
                end
            end
            MODE_READ: begin
                if (pos < fill) begin
                    res.read_key     = keys[pos];
                    res.read_payload = payloads[pos];
                    res.ok           = 1'b1;
                end
            end
            default: begin
                // The unused code leaves the table alone and reports a failure.
            end
        endcase
        res.entry_count = CNT_BITS'(fill);
        expected_results.push_back(res);
    endfunction

    // Compare one result transfer with the oldest expectation.
    function void check_result(table_result_t got);
        table_result_t want;
        if (expected_results.size() == 0) begin
            $error("result transfer with no expectation waiting");
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.ok !== want.ok) begin
            $error("ok: expected %0h, got %0h", want.ok, got.ok);
            errors++;
        end
        if (got.read_key !== want.read_key) begin
            $error("read_key: expected %0h, got %0h", want.read_key, got.read_key);
            errors++;
        end
        if (got.read_payload !== want.read_payload) begin
            $error("read_payload: expected %0h, got %0h", want.read_payload,
                   got.read_payload);
            errors++;
        end
        if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   got.entry_count);
            errors++;
        end
    endfunction
endclass

module tb_top;

    // The mode code that the block must ignore.
    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int         ITEMS_PER_PHASE = 190;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [1:0]              i_mode;
    logic [KEY_BITS-1:0]     i_entry_key;
    logic [PAYLOAD_BITS-1:0] i_entry_payload;
    logic [POS_BITS-1:0]     i_position;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_ok;
    logic [KEY_BITS-1:0]     o_read_key;
    logic [PAYLOAD_BITS-1:0] o_read_payload;
    logic [CNT_BITS-1:0]     o_entry_count;

    sorted_table_shadow shadow = new();

    // Percent of cycles in which the sender idles and the receiver stalls.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    bit          filling   = 1'b1;

    sorted_table_insert_delete dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_entry_key     (i_entry_key),
        .i_entry_payload (i_entry_payload),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_ok            (o_ok),
        .o_read_key      (o_read_key),
        .o_read_payload  (o_read_payload),
        .o_entry_count   (o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: stall at random according to the current phase.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Both channels are sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                shadow.check_result({o_ok, o_read_key, o_read_payload, o_entry_count});
            if (i_valid && o_ready)
                shadow.apply_op(i_mode, i_entry_key, i_entry_payload, i_position);
        end
    end

    // Offer one operation and hold it until its transfer; entered and left at a falling edge.
    task automatic send_op(input logic [1:0] mode, input logic [KEY_BITS-1:0] key,
                           input logic [PAYLOAD_BITS-1:0] payload,
                           input logic [POS_BITS-1:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= mode;
        i_entry_key     <= key;
        i_entry_payload <= payload;
        i_position      <= pos;
        do
            @(posedge i_clk);
        while (!o_ready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (shadow.outstanding() != 0)
            @(negedge i_clk);
    endtask

    // One random operation, steered so the table swings between empty and full.
    task automatic send_random_op();
        int unsigned             fill_now;
        int unsigned             roll;
        logic [1:0]              mode;
        logic [KEY_BITS-1:0]     key;
        logic [POS_BITS-1:0]     pos;
        fill_now = shadow.level();
        if (fill_now == TABLE_DEPTH && $urandom_range(2) == 0)
            filling = 1'b0;
        else if (fill_now == 0)
            filling = 1'b1;
        else if ($urandom_range(63) == 0)
            filling = !filling;

        roll = $urandom_range(99);
        if (roll < 2)
            mode = MODE_RESERVED;
        else if (roll < (filling ? 72 : 20))
            mode = MODE_INSERT;
        else if (roll < (filling ? 85 : 75))
            mode = MODE_DELETE;
        else
            mode = MODE_READ;

        // Narrow keys make duplicates common; the extremes test the ordering edges.
        case ($urandom_range(3))
            0:       key = KEY_BITS'($urandom_range(15));
            1:       key = $urandom_range(1) ? '1 : '0;
            default: key = KEY_BITS'($urandom);
        endcase

        if (fill_now != 0 && $urandom_range(3) != 0)
            pos = POS_BITS'($urandom_range(fill_now - 1));
        else
            pos = POS_BITS'($urandom_range(31));

        send_op(mode, key, $urandom, pos);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_ready         = 1'b0;
        i_mode          = MODE_INSERT;
        i_entry_key     = '0;
        i_entry_payload = '0;
        i_position      = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, key extremes, equal keys, range limits, unused code.
        send_op(MODE_READ, '0, '0, 5'd0);
        send_op(MODE_DELETE, '0, '0, 5'd0);
        send_op(MODE_RESERVED, '0, '0, 5'd0);
        send_op(MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 5'd0);
        send_op(MODE_INSERT, 16'h0000, 32'h0000_0000, 5'd31);
        send_op(MODE_INSERT, 16'h8000, 32'hA5A5_A5A5, 5'd0);
        send_op(MODE_INSERT, 16'h8000, 32'h5A5A_5A5A, 5'd0);
        send_op(MODE_INSERT, 16'h0000, 32'h0000_0001, 5'd0);
        for (int p = 0; p < 5; p++)
            send_op(MODE_READ, '0, '0, POS_BITS'(p));
        send_op(MODE_READ, '0, '0, 5'd5);
        send_op(MODE_READ, '0, '0, 5'd31);
        send_op(MODE_RESERVED, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
        send_op(MODE_DELETE, '0, '0, 5'd5);
        send_op(MODE_DELETE, '0, '0, 5'd2);
        send_op(MODE_DELETE, '0, '0, 5'd0);
        send_op(MODE_READ, '0, '0, 5'd0);
        send_op(MODE_READ, '0, '0, 5'd1);
        send_op(MODE_READ, '0, '0, 5'd2);
        send_op(MODE_DELETE, '0, '0, 5'd2);
        send_op(MODE_READ, '0, '0, 5'd2);
        drain();

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 81; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_op();
            drain();
        end

        repeat (4) @(negedge i_clk);
        if (shadow.errors == 0 && shadow.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
